// ===== rtl/biquad_cascade_envelope_follower_defines.svh =====
// Assertion macros shared by the biquad cascade envelope follower RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BIQUAD_CASCADE_ENVELOPE_FOLLOWER_DEFINES_SVH
`define BIQUAD_CASCADE_ENVELOPE_FOLLOWER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BQEF_IMPLIES(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BQEF_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bqef_pkg.sv =====
// Package for the biquad cascade envelope follower: widths, codes, defaults.
// No dependencies; used by bqef_ram and biquad_cascade_envelope_follower.
package bqef_pkg;

	localparam int MAX_STAGES_DEF = 8;
	localparam int MAX_BLOCK_DEF  = 4096;
	localparam int NCOEF          = 5;

	localparam int COEF_W   = 24;
	localparam int SIG_W    = 18;
	localparam int SAMPLE_W = 16;
	localparam int ENV_W    = 17;
	localparam int PROD_W   = COEF_W + SIG_W;
	localparam int ACC_W    = PROD_W + 3;

	localparam logic [ENV_W-1:0] SIG_MAX = 17'd131071;
	localparam logic [ENV_W-1:0] UNITY   = 17'd65536;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_SAMPLE = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [1:0] REG_STAGE_COUNT = 2'd0;
	localparam logic [1:0] REG_ATTACK      = 2'd1;
	localparam logic [1:0] REG_RELEASE     = 2'd2;

endpackage

// ===== rtl/biquad_cascade_envelope_follower.sv =====
// Biquad cascade with attack/release envelope follower and block statistics.
// Depends on bqef_pkg, bqef_ram and biquad_cascade_envelope_follower_defines.svh.
//
// While a sample request is processed, in_stall stays high through the MAC
// states of every active stage, the follower and statistics states and the
// load of the output register, all on one shared 24x18 multiplier. A
// request with last set also runs the one-bit-per-cycle divider and square
// root that produce the block RMS and RMS/peak ratio (divider width W = 47
// with the default block size). The second division is skipped when the
// peak is zero. Coefficient loads, clears and unused codes leave in_stall low.
// The block takes no new request while it works on a sample, but a finished
// result may wait in the output register while the next request is accepted;
// a second finished result then waits until the first is taken. Coefficients
// live in a RAM whose entries read as zero until loaded after reset or a clear.
`include "biquad_cascade_envelope_follower_defines.svh"

module biquad_cascade_envelope_follower #(
	parameter int MAX_STAGES = bqef_pkg::MAX_STAGES_DEF,
	parameter int MAX_BLOCK  = bqef_pkg::MAX_BLOCK_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      action,
	input  logic [2:0]                      stage,
	input  logic [2:0]                      coef_select,
	input  logic signed [bqef_pkg::COEF_W-1:0]   coef_value,
	input  logic signed [bqef_pkg::SAMPLE_W-1:0] sample,
	input  logic                            first,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bqef_pkg::ENV_W-1:0]      envelope,
	output logic                            stats_valid,
	output logic [bqef_pkg::ENV_W-1:0]      block_peak,
	output logic [bqef_pkg::ENV_W-1:0]      block_rms,
	output logic [bqef_pkg::ENV_W-1:0]      rms_peak_ratio,
	output logic                            block_overflow,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [bqef_pkg::ENV_W-1:0]      cfg_data
);

	localparam int ENV_W  = bqef_pkg::ENV_W;
	localparam int SIG_W  = bqef_pkg::SIG_W;
	localparam int COEF_W = bqef_pkg::COEF_W;
	localparam int PROD_W = bqef_pkg::PROD_W;
	localparam int ACC_W  = bqef_pkg::ACC_W;
	localparam int NCOEF  = bqef_pkg::NCOEF;

	localparam int CDEPTH = NCOEF * MAX_STAGES;
	localparam int AW     = $clog2(CDEPTH);
	localparam int SIW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CW     = $clog2(MAX_BLOCK + 1);
	localparam int SW     = 2 * ENV_W + CW;
	localparam int DVW    = (CW > ENV_W) ? CW : ENV_W;
	localparam int DIV_W  = (SW > 33) ? SW : 33;
	localparam int SQ_W   = DIV_W + (DIV_W % 2);
	localparam int H      = SQ_W / 2;
	localparam int IT_W   = $clog2(DIV_W + 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MAC     = 4'd1;
	localparam logic [3:0] ST_ENV_MUL = 4'd2;
	localparam logic [3:0] ST_ENV_ADD = 4'd3;
	localparam logic [3:0] ST_SQ_MUL  = 4'd4;
	localparam logic [3:0] ST_SQ_ADD  = 4'd5;
	localparam logic [3:0] ST_DIV1    = 4'd6;
	localparam logic [3:0] ST_SQRT    = 4'd7;
	localparam logic [3:0] ST_DIV2    = 4'd8;
	localparam logic [3:0] ST_OUT     = 4'd9;

	// Configuration registers.
	logic [3:0]       stage_count_q;
	logic [ENV_W-1:0] attack_q;
	logic [ENV_W-1:0] release_q;

	// Sequencer and datapath state.
	logic [3:0]              state_q;
	logic [SIW-1:0]          st_q;
	logic [2:0]              ph_q;
	logic [4:0]              n_q;
	logic                    last_q;
	logic signed [SIG_W-1:0] x_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                    neg_q;
	logic                    cvld_rd_q;

	logic signed [SIG_W-1:0] xh1_q [MAX_STAGES];
	logic signed [SIG_W-1:0] xh2_q [MAX_STAGES];
	logic signed [SIG_W-1:0] yh1_q [MAX_STAGES];
	logic signed [SIG_W-1:0] yh2_q [MAX_STAGES];
	logic [CDEPTH-1:0]       cvld_q;

	logic [ENV_W-1:0] env_q;
	logic [ENV_W-1:0] peak_q;
	logic [SW-1:0]    sum_q;
	logic [CW-1:0]    cnt_q;
	logic             over_q;

	logic [DIV_W-1:0] quo_q;
	logic [DVW-1:0]   rem_q;
	logic [DVW-1:0]   den_q;
	logic [IT_W-1:0]  it_q;
	logic [SQ_W-1:0]  sqv_q;
	logic [H-1:0]     root_q;
	logic [H:0]       srem_q;
	logic [ENV_W-1:0] rms_q;
	logic [ENV_W-1:0] ratio_q;

	logic             out_valid_q;
	logic [ENV_W-1:0] envelope_q;
	logic             stats_valid_q;
	logic [ENV_W-1:0] block_peak_q;
	logic [ENV_W-1:0] block_rms_q;
	logic [ENV_W-1:0] ratio_out_q;
	logic             overflow_q;

	// Request decode.
	logic in_acc;
	logic load_ok;
	logic [4:0] n_cfg;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_ok  = ({2'b00, stage} < 5'(MAX_STAGES)) && (coef_select < 3'(NCOEF));
	assign n_cfg    = ({1'b0, stage_count_q} > 5'(MAX_STAGES)) ? 5'(MAX_STAGES)
		: {1'b0, stage_count_q};

	// Coefficient RAM.
	logic [AW-1:0]     c_waddr;
	logic [AW-1:0]     c_raddr;
	logic [COEF_W-1:0] c_rdata;
	logic              c_we;
	assign c_we    = in_acc && (action == bqef_pkg::ACT_LOAD) && load_ok;
	assign c_waddr = AW'(8'(stage) * 8'(NCOEF) + 8'(coef_select));
	assign c_raddr = AW'(8'(st_q) * 8'(NCOEF) + 8'(ph_q));

	bqef_ram #(
		.WIDTH(COEF_W),
		.DEPTH(CDEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(c_waddr),
		.wdata(coef_value),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	// Shared multiplier operand selection.
	logic [2:0]               kk;
	logic signed [SIG_W-1:0]  mac_op;
	logic signed [COEF_W-1:0] mul_a;
	logic signed [SIG_W-1:0]  mul_b;
	logic [SIG_W-1:0]         r_abs;
	logic [ENV_W-1:0]         r_sat;
	logic                     up;
	logic [ENV_W-1:0]         diff;
	logic [ENV_W-1:0]         k_sel;
	logic [ENV_W-1:0]         att_sat;
	logic [ENV_W-1:0]         rel_sat;

	assign kk = ph_q - 3'd1;
	assign att_sat = (attack_q > bqef_pkg::UNITY) ? bqef_pkg::UNITY : attack_q;
	assign rel_sat = (release_q > bqef_pkg::UNITY) ? bqef_pkg::UNITY : release_q;
	assign r_abs = x_q[SIG_W-1] ? SIG_W'(-x_q) : SIG_W'(x_q);
	assign r_sat = (r_abs > {1'b0, bqef_pkg::SIG_MAX}) ? bqef_pkg::SIG_MAX : r_abs[ENV_W-1:0];
	assign up    = r_sat > env_q;
	assign diff  = up ? (r_sat - env_q) : (env_q - r_sat);
	assign k_sel = up ? att_sat : rel_sat;

	always_comb begin
		case (kk)
			3'd0:    mac_op = x_q;
			3'd1:    mac_op = xh1_q[st_q];
			3'd2:    mac_op = xh2_q[st_q];
			3'd3:    mac_op = yh1_q[st_q];
			3'd4:    mac_op = yh2_q[st_q];
			default: mac_op = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_MAC: begin
				mul_a = cvld_rd_q ? c_rdata : '0;
				mul_b = mac_op;
			end
			ST_ENV_MUL: begin
				mul_a = COEF_W'(k_sel);
				mul_b = SIG_W'(diff);
			end
			ST_SQ_MUL: begin
				mul_a = COEF_W'(env_q);
				mul_b = SIG_W'(env_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Stage result: round half up, floor shift and saturate.
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-21:0] shr;
	logic signed [SIG_W-1:0]  y_sat;
	assign rnd = acc_q + ACC_W'(1 << 19);
	assign shr = rnd[ACC_W-1:20];
	always_comb begin
		if (shr > (ACC_W-20)'(131071)) begin
			y_sat = SIG_W'(131071);
		end else if (shr < -(ACC_W-20)'(131072)) begin
			y_sat = -SIG_W'(131072);
		end else begin
			y_sat = shr[SIG_W-1:0];
		end
	end

	// Follower step and statistics update.
	logic [PROD_W-1:0] step_full;
	logic [ENV_W-1:0]  step;
	logic [ENV_W-1:0]  env_nx;
	logic              cnt_room;
	logic [SW-1:0]     sum_nx;
	logic [CW-1:0]     cnt_nx;
	assign step_full = PROD_W'(prod_q) + PROD_W'(32768);
	assign step      = step_full[16 +: ENV_W];
	assign env_nx    = up ? (env_q + step) : (env_q - step);
	assign cnt_room  = cnt_q < CW'(MAX_BLOCK);
	assign sum_nx    = cnt_room ? (sum_q + SW'(prod_q)) : sum_q;
	assign cnt_nx    = cnt_room ? (cnt_q + CW'(1)) : cnt_q;

	// Shared restoring divider step.
	logic [DVW:0]     d_sh;
	logic             d_ge;
	logic [DIV_W-1:0] quo_nx;
	assign d_sh   = {rem_q, quo_q[DIV_W-1]};
	assign d_ge   = d_sh >= {1'b0, den_q};
	assign quo_nx = {quo_q[DIV_W-2:0], d_ge};

	// Square root step, two radicand bits per cycle.
	logic [H+2:0] s_sh;
	logic [H+2:0] s_trial;
	logic         s_ge;
	logic [H-1:0] root_nx;
	logic [ENV_W-1:0] rms_nx;
	assign s_sh    = {srem_q, sqv_q[SQ_W-1:SQ_W-2]};
	assign s_trial = {1'b0, root_q, 2'b01};
	assign s_ge    = s_sh >= s_trial;
	assign root_nx = {root_q[H-2:0], s_ge};
	assign rms_nx  = (root_nx > H'(bqef_pkg::SIG_MAX)) ? bqef_pkg::SIG_MAX
		: root_nx[ENV_W-1:0];

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Configuration port; the user must write only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= '0;
			attack_q      <= bqef_pkg::UNITY;
			release_q     <= bqef_pkg::UNITY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bqef_pkg::REG_STAGE_COUNT: stage_count_q <= cfg_data[3:0];
				bqef_pkg::REG_ATTACK:      attack_q      <= cfg_data;
				bqef_pkg::REG_RELEASE:     release_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state, histories and statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q    <= '0;
			ph_q    <= '0;
			n_q     <= '0;
			last_q  <= 1'b0;
			cvld_q  <= '0;
			for (int i = 0; i < MAX_STAGES; i++) begin
				xh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh1_q[i] <= '0;
				yh2_q[i] <= '0;
			end
			env_q  <= '0;
			peak_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			over_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (action)
							bqef_pkg::ACT_LOAD: begin
								if (load_ok) begin
									cvld_q[c_waddr]     <= 1'b1;
									xh1_q[SIW'(stage)] <= '0;
									xh2_q[SIW'(stage)] <= '0;
									yh1_q[SIW'(stage)] <= '0;
									yh2_q[SIW'(stage)] <= '0;
								end
							end
							bqef_pkg::ACT_CLEAR: begin
								cvld_q <= '0;
								for (int i = 0; i < MAX_STAGES; i++) begin
									xh1_q[i] <= '0;
									xh2_q[i] <= '0;
									yh1_q[i] <= '0;
									yh2_q[i] <= '0;
								end
								env_q  <= '0;
								peak_q <= '0;
								sum_q  <= '0;
								cnt_q  <= '0;
								over_q <= 1'b0;
							end
							bqef_pkg::ACT_SAMPLE: begin
								if (first) begin
									env_q  <= '0;
									peak_q <= '0;
									sum_q  <= '0;
									cnt_q  <= '0;
									over_q <= 1'b0;
								end
								last_q  <= last;
								n_q     <= n_cfg;
								st_q    <= '0;
								ph_q    <= '0;
								state_q <= (n_cfg == 5'd0) ? ST_ENV_MUL : ST_MAC;
							end
							default: ;
						endcase
					end
				end
				ST_MAC: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd7) begin
						xh2_q[st_q] <= xh1_q[st_q];
						xh1_q[st_q] <= x_q;
						yh2_q[st_q] <= yh1_q[st_q];
						yh1_q[st_q] <= y_sat;
						if (5'(st_q) == n_q - 5'd1) begin
							state_q <= ST_ENV_MUL;
						end else begin
							st_q <= st_q + SIW'(1);
						end
					end
				end
				ST_ENV_MUL: state_q <= ST_ENV_ADD;
				ST_ENV_ADD: begin
					env_q   <= env_nx;
					state_q <= ST_SQ_MUL;
				end
				ST_SQ_MUL: state_q <= ST_SQ_ADD;
				ST_SQ_ADD: begin
					if (env_q > peak_q) begin
						peak_q <= env_q;
					end
					sum_q <= sum_nx;
					cnt_q <= cnt_nx;
					if (!cnt_room) begin
						over_q <= 1'b1;
					end
					state_q <= last_q ? ST_DIV1 : ST_OUT;
				end
				ST_DIV1: begin
					if (it_q == IT_W'(DIV_W - 1)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (it_q == IT_W'(H - 1)) begin
						state_q <= (peak_q == '0) ? ST_OUT : ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (it_q == IT_W'(DIV_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		prod_q    <= mul_a * mul_b;
		cvld_rd_q <= cvld_q[c_raddr];
		case (state_q)
			ST_IDLE: begin
				x_q <= SIG_W'(sample);
			end
			ST_MAC: begin
				neg_q <= (kk >= 3'd3);
				if (ph_q == 3'd1) begin
					acc_q <= '0;
				end else if (ph_q inside {[3'd2:3'd6]}) begin
					acc_q <= neg_q ? (acc_q - ACC_W'(prod_q)) : (acc_q + ACC_W'(prod_q));
				end
				if (ph_q == 3'd7) begin
					x_q <= y_sat;
				end
			end
			ST_SQ_ADD: begin
				quo_q <= DIV_W'(sum_nx);
				den_q <= DVW'(cnt_nx);
				rem_q <= '0;
				it_q  <= '0;
				rms_q <= '0;
				ratio_q <= '0;
			end
			ST_DIV1: begin
				quo_q <= quo_nx;
				rem_q <= d_ge ? DVW'(d_sh - {1'b0, den_q}) : DVW'(d_sh);
				if (it_q == IT_W'(DIV_W - 1)) begin
					sqv_q  <= SQ_W'(quo_nx);
					root_q <= '0;
					srem_q <= '0;
					it_q   <= '0;
				end else begin
					it_q <= it_q + IT_W'(1);
				end
			end
			ST_SQRT: begin
				sqv_q  <= {sqv_q[SQ_W-3:0], 2'b00};
				root_q <= root_nx;
				srem_q <= s_ge ? (H+1)'(s_sh - s_trial) : (H+1)'(s_sh);
				if (it_q == IT_W'(H - 1)) begin
					rms_q <= rms_nx;
					quo_q <= DIV_W'({rms_nx, 16'b0});
					den_q <= DVW'(peak_q);
					rem_q <= '0;
					it_q  <= '0;
				end else begin
					it_q <= it_q + IT_W'(1);
				end
			end
			ST_DIV2: begin
				quo_q <= quo_nx;
				rem_q <= d_ge ? DVW'(d_sh - {1'b0, den_q}) : DVW'(d_sh);
				it_q  <= it_q + IT_W'(1);
				if (it_q == IT_W'(DIV_W - 1)) begin
					ratio_q <= (quo_nx > DIV_W'(bqef_pkg::UNITY)) ? bqef_pkg::UNITY
						: quo_nx[ENV_W-1:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			envelope_q    <= env_q;
			stats_valid_q <= last_q;
			block_peak_q  <= last_q ? peak_q : '0;
			block_rms_q   <= last_q ? rms_q : '0;
			ratio_out_q   <= last_q ? ratio_q : '0;
			overflow_q    <= last_q && over_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign envelope       = envelope_q;
	assign stats_valid    = stats_valid_q;
	assign block_peak     = block_peak_q;
	assign block_rms      = block_rms_q;
	assign rms_peak_ratio = ratio_out_q;
	assign block_overflow = overflow_q;

	`BQEF_NEXT(a_out_hold, clk, arst_n, state_q == ST_OUT && out_valid && out_stall, state_q == ST_OUT, "finished result left the sequencer while output was blocked")
	`BQEF_NEXT(a_out_load, clk, arst_n, out_load, out_valid, "loaded result not presented")
	`BQEF_IMPLIES(a_mac_range, clk, arst_n, state_q == ST_MAC, 5'(st_q) < n_q, "stage index beyond active stage count")
	`BQEF_NEXT(a_short_req, clk, arst_n, in_valid && !in_stall && action != bqef_pkg::ACT_SAMPLE, state_q == ST_IDLE, "non-sample request did not finish in one cycle")

endmodule

// ===== rtl/bqef_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on bqef_pkg for its default sizes.
module bqef_ram #(
	parameter int WIDTH = bqef_pkg::COEF_W,
	parameter int DEPTH = bqef_pkg::NCOEF * bqef_pkg::MAX_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== dv/biquad_cascade_envelope_follower_tb.sv =====
// Self-checking testbench for biquad_cascade_envelope_follower: random and directed
// coefficient loads, samples and block flags checked against an inline predictor.
// Depends on bqef_pkg and the RTL of the block.
module biquad_cascade_envelope_follower_tb;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         SETTLE     = 250;
	localparam longint     LIMIT      = 4_000_000;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         stage;
		logic [2:0]         coef_select;
		logic signed [23:0] coef_value;
		logic signed [15:0] sample;
		logic               first;
		logic               last;
	} req_t;

	typedef struct packed {
		logic [16:0] envelope;
		logic        stats_valid;
		logic [16:0] block_peak;
		logic [16:0] block_rms;
		logic [16:0] rms_peak_ratio;
		logic        block_overflow;
	} env_res_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic [1:0] action;
	logic [2:0] stage, coef_select;
	logic signed [bqef_pkg::COEF_W-1:0] coef_value;
	logic signed [bqef_pkg::SAMPLE_W-1:0] sample;
	logic first, last;
	logic out_valid, out_stall;
	logic [bqef_pkg::ENV_W-1:0] envelope, block_peak, block_rms, rms_peak_ratio;
	logic stats_valid, block_overflow;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [bqef_pkg::ENV_W-1:0] cfg_data;

	biquad_cascade_envelope_follower u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .stage(stage), .coef_select(coef_select),
		.coef_value(coef_value), .sample(sample), .first(first), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.envelope(envelope), .stats_valid(stats_valid), .block_peak(block_peak),
		.block_rms(block_rms), .rms_peak_ratio(rms_peak_ratio),
		.block_overflow(block_overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	req_t     pending_reqs[$];
	env_res_t expected_envs[$];
	int       errors;
	longint   cycles;
	bit       taken;
	int       burst_left, gap_left, sender_mode, stall_mode, stall_phase;

	// Predictor state and its copy of the registers.
	logic [3:0]         stage_count_q;
	logic [16:0]        attack_q, release_q;
	logic signed [23:0] coef_mem[40];
	logic signed [17:0] x_hist[16], y_hist[16];
	longint unsigned    env_lvl, peak_lvl, sq_sum, n_samples;
	bit                 over_q;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void clear_block();
		env_lvl = 0;
		peak_lvl = 0;
		sq_sum = 0;
		n_samples = 0;
		over_q = 0;
	endfunction

	function automatic void clear_filters();
		for (int i = 0; i < 40; i++)
			coef_mem[i] = '0;
		for (int i = 0; i < 16; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
	endfunction

	function automatic void predict_envelope(req_t it);
		longint x, acc, y, r, k, rms, ratio;
		int n, b;
		env_res_t res;
		if (it.action == bqef_pkg::ACT_LOAD) begin
			if (it.coef_select < 3'(bqef_pkg::NCOEF)) begin
				coef_mem[int'(it.stage) * bqef_pkg::NCOEF + int'(it.coef_select)] =
					it.coef_value;
				x_hist[2 * it.stage] = '0;
				x_hist[2 * it.stage + 1] = '0;
				y_hist[2 * it.stage] = '0;
				y_hist[2 * it.stage + 1] = '0;
			end
			return;
		end
		if (it.action == bqef_pkg::ACT_CLEAR) begin
			clear_filters();
			clear_block();
			return;
		end
		if (it.action != bqef_pkg::ACT_SAMPLE)
			return;
		if (it.first)
			clear_block();
		x = longint'(it.sample);
		n = (int'(stage_count_q) > bqef_pkg::MAX_STAGES_DEF) ? bqef_pkg::MAX_STAGES_DEF
			: int'(stage_count_q);
		for (int s = 0; s < n; s++) begin
			b = s * bqef_pkg::NCOEF;
			acc = longint'(coef_mem[b]) * x
				+ longint'(coef_mem[b + 1]) * longint'(x_hist[2 * s])
				+ longint'(coef_mem[b + 2]) * longint'(x_hist[2 * s + 1])
				- longint'(coef_mem[b + 3]) * longint'(y_hist[2 * s])
				- longint'(coef_mem[b + 4]) * longint'(y_hist[2 * s + 1]);
			y = (acc + (longint'(1) << 19)) >>> 20;
			if (y > 131071)
				y = 131071;
			if (y < -131072)
				y = -131072;
			x_hist[2 * s + 1] = x_hist[2 * s];
			x_hist[2 * s] = 18'(x);
			y_hist[2 * s + 1] = y_hist[2 * s];
			y_hist[2 * s] = 18'(y);
			x = y;
		end
		r = (x < 0) ? -x : x;
		if (r > 131071)
			r = 131071;
		if (r > longint'(env_lvl)) begin
			k = longint'((attack_q > bqef_pkg::UNITY) ? bqef_pkg::UNITY : attack_q);
			env_lvl += (k * (r - longint'(env_lvl)) + 32768) >> 16;
		end else begin
			k = longint'((release_q > bqef_pkg::UNITY) ? bqef_pkg::UNITY : release_q);
			env_lvl -= (k * (longint'(env_lvl) - r) + 32768) >> 16;
		end
		if (env_lvl > peak_lvl)
			peak_lvl = env_lvl;
		if (n_samples < longint'(bqef_pkg::MAX_BLOCK_DEF)) begin
			sq_sum += env_lvl * env_lvl;
			n_samples++;
		end else
			over_q = 1;
		res = '0;
		res.envelope = env_lvl[16:0];
		if (it.last) begin
			rms = 0;
			ratio = 0;
			if (n_samples != 0)
				rms = int_sqrt(sq_sum / n_samples);
			if (rms > 131071)
				rms = 131071;
			if (peak_lvl != 0) begin
				ratio = (rms << 16) / longint'(peak_lvl);
				if (ratio > longint'(bqef_pkg::UNITY))
					ratio = longint'(bqef_pkg::UNITY);
			end
			res.stats_valid = 1'b1;
			res.block_peak = peak_lvl[16:0];
			res.block_rms = rms[16:0];
			res.rms_peak_ratio = ratio[16:0];
			res.block_overflow = over_q;
		end
		expected_envs.push_back(res);
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d at cycle %0d", field, got, want, cycles);
		errors++;
	endtask

	// Sender: bursts of requests separated by random gaps, except in sender mode 0.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !taken)) begin
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_reqs.size() != 0) begin
			req_t it;
			it = pending_reqs.pop_front();
			in_valid <= 1'b1;
			{action, stage, coef_select, coef_value, sample, first, last} <= it;
			if (burst_left <= 1) begin
				burst_left <= int'($urandom_range(1, 12));
				gap_left <= (sender_mode == 0) ? 0 : int'($urandom_range(0, 6));
			end else
				burst_left <= burst_left - 1;
		end else
			in_valid <= 1'b0;
	end

	// Receiver stall pattern.
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= (stall_phase % 7) < 3;
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			predict_envelope({action, stage, coef_select, coef_value, sample, first, last});
		if (arst_n && out_valid && !out_stall) begin
			if (expected_envs.size() == 0) begin
				report_mismatch("out_valid", 1, 0);
			end else begin
				env_res_t want;
				want = expected_envs.pop_front();
				if (envelope !== want.envelope)
					report_mismatch("envelope", envelope, want.envelope);
				if (stats_valid !== want.stats_valid)
					report_mismatch("stats_valid", stats_valid, want.stats_valid);
				if (block_peak !== want.block_peak)
					report_mismatch("block_peak", block_peak, want.block_peak);
				if (block_rms !== want.block_rms)
					report_mismatch("block_rms", block_rms, want.block_rms);
				if (rms_peak_ratio !== want.rms_peak_ratio)
					report_mismatch("rms_peak_ratio", rms_peak_ratio, want.rms_peak_ratio);
				if (block_overflow !== want.block_overflow)
					report_mismatch("block_overflow", block_overflow, want.block_overflow);
			end
		end
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic req_t noise_req();
		req_t it;
		it.action = 2'($urandom_range(0, 3));
		it.stage = 3'($urandom);
		it.coef_select = 3'($urandom);
		it.coef_value = 24'($urandom);
		it.sample = 16'($urandom);
		it.first = 1'($urandom);
		it.last = 1'($urandom);
		return it;
	endfunction

	task automatic push_load(int st, int sel, logic signed [23:0] val);
		req_t it;
		it = noise_req();
		it.action = bqef_pkg::ACT_LOAD;
		it.stage = 3'(st);
		it.coef_select = 3'(sel);
		it.coef_value = val;
		pending_reqs.push_back(it);
	endtask

	task automatic push_sample(logic signed [15:0] s, bit f, bit l);
		req_t it;
		it = noise_req();
		it.action = bqef_pkg::ACT_SAMPLE;
		it.sample = s;
		it.first = f;
		it.last = l;
		pending_reqs.push_back(it);
	endtask

	task automatic push_bare(logic [1:0] act);
		req_t it;
		it = noise_req();
		it.action = act;
		pending_reqs.push_back(it);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			bqef_pkg::REG_STAGE_COUNT: stage_count_q = val[3:0];
			bqef_pkg::REG_ATTACK: attack_q = val;
			default: release_q = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_envs.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// A stable-ish filter set with random content, then a few blocks of samples.
	task automatic push_filter_blocks(int nblocks);
		int len;
		for (int s = 0; s < bqef_pkg::MAX_STAGES_DEF; s++) begin
			push_load(s, 0, 24'(int'($urandom_range(0, 3 << 20)) - (3 << 19)));
			push_load(s, 1, 24'(int'($urandom_range(0, 1 << 20)) - (1 << 19)));
			push_load(s, 2, 24'(int'($urandom_range(0, 1 << 19)) - (1 << 18)));
			push_load(s, 3, 24'(int'($urandom_range(0, 1 << 20)) - (1 << 19)));
			push_load(s, 4, 24'(int'($urandom_range(0, 1 << 19)) - (1 << 18)));
		end
		for (int b = 0; b < nblocks; b++) begin
			len = int'($urandom_range(1, 10));
			for (int i = 0; i < len; i++)
				push_sample(16'($urandom), (i == 0) && ($urandom_range(0, 5) != 0),
					i == len - 1);
		end
	endtask

	logic [16:0] coef_picks[4] = '{17'd0, 17'd65536, 17'd131071, 17'd20000};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		stage = '0;
		coef_select = '0;
		coef_value = '0;
		sample = '0;
		first = 1'b0;
		last = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		taken = 1'b0;
		burst_left = 1;
		gap_left = 0;
		sender_mode = 0;
		stall_mode = 0;
		stall_phase = 0;
		stage_count_q = '0;
		attack_q = bqef_pkg::UNITY;
		release_q = bqef_pkg::UNITY;
		clear_filters();
		clear_block();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every action, ignored loads, clear.
		write_reg(bqef_pkg::REG_STAGE_COUNT, 17'd2);
		write_reg(bqef_pkg::REG_ATTACK, bqef_pkg::UNITY);
		write_reg(bqef_pkg::REG_RELEASE, bqef_pkg::UNITY);
		push_load(0, 0, 24'sh100000);
		push_sample(16'sh7fff, 1, 0);
		push_sample(-16'sh8000, 0, 0);
		push_sample(16'sh0000, 0, 1);
		push_load(1, 0, -24'sh800000);
		push_load(1, 1, 24'sh7fffff);
		push_load(0, 3, 24'sh7fffff);
		push_load(0, 4, -24'sh800000);
		push_sample(16'sh7fff, 1, 0);
		push_sample(-16'sh8000, 0, 1);
		push_load(7, 2, 24'sh123456);
		push_load(3, 5, 24'sh7fffff);
		push_load(3, 7, 24'sh7fffff);
		push_bare(ACT_UNUSED);
		push_sample(16'sh4000, 0, 1);
		push_bare(bqef_pkg::ACT_CLEAR);
		push_sample(16'sh7fff, 0, 1);
		push_sample(16'sh0001, 1, 1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			sender_mode = ph % 3;
			stall_mode = ph % 3;
			write_reg(bqef_pkg::REG_STAGE_COUNT, 17'((ph == 0) ? 0 : (ph == 1) ? 15 :
				(ph == 2) ? 8 : int'($urandom_range(0, 15))));
			write_reg(bqef_pkg::REG_ATTACK,
				(ph < 4) ? coef_picks[ph] : 17'($urandom_range(0, 131071)));
			write_reg(bqef_pkg::REG_RELEASE,
				(ph < 4) ? coef_picks[3 - ph] : 17'($urandom_range(0, 131071)));
			push_filter_blocks(6);
			for (int i = 0; i < 8; i++)
				pending_reqs.push_back(noise_req());
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
